// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/tmps_pkg.sv
// Types, codes and constants of the trie pattern search core.
package tmps_pkg;

  localparam int NODES_DEF    = 256;
  localparam int MAXLEN_DEF   = 16;
  localparam int ALPHABET_DEF = 26;
  localparam int MAX_TEXT     = 65536;
  localparam int POS_LIMIT    = ((MAX_TEXT - 1) < 65535) ? (MAX_TEXT - 1) : 65535;
  localparam int MAX_RESULTS  = 16;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam int TAG_W        = 7;

  localparam logic [1:0] CMD_PATTERN = 2'd0;
  localparam logic [1:0] CMD_TEXT    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] ST_MATCH = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [4:0] symbol;
    logic       last;
    logic [5:0] pattern_id;
  } req_t;

  typedef struct packed {
    logic [5:0]  match_id;
    logic [15:0] position;
    logic [1:0]  status;
    logic        run_end;
  } res_t;

  typedef enum logic [1:0] {OP_LOAD, OP_TEXT, OP_CLEAR, OP_NOP} op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] symbol;
    logic       last;
    logic [5:0] pattern_id;
  } job_t;

  typedef struct packed {
    logic sweeping;
    logic take;
  } back_stat_t;

  typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_LOAD, S_TEXT, S_DONE} state_t;

endpackage

// File: hdl/tmps_front.sv
// Front end: request intake, command decode and a two-entry job queue.
module tmps_front import tmps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  req_t       req,
  input  back_stat_t stat,
  output logic       busy,
  output logic       q_valid,
  output job_t       q_job
);

  job_t       slot [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  job_t       job;

  always_comb begin
    job.symbol     = req.symbol;
    job.last       = req.last;
    job.pattern_id = req.pattern_id;
    unique case (req.cmd)
      CMD_PATTERN: job.op = OP_LOAD;
      CMD_TEXT:    job.op = OP_TEXT;
      CMD_CLEAR:   job.op = OP_CLEAR;
      default:     job.op = OP_NOP;
    endcase
  end

  assign busy    = (count == 2'd2) || stat.sweeping;
  assign push    = start && !busy;
  assign pop     = stat.take;
  assign q_valid = (count != 2'd0);
  assign q_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// File: hdl/tmps_back.sv
// Back end: trie node store, pattern loader, walker sequencer and result stage.
module tmps_back import tmps_pkg::*; #(
  parameter int NODES           = NODES_DEF,
  parameter int MAX_PATTERN_LEN = MAXLEN_DEF,
  parameter int ALPHABET        = ALPHABET_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output back_stat_t stat,
  output logic       strobe,
  output res_t       result
);

  localparam int NW   = $clog2(NODES);
  localparam int UW   = $clog2(NODES + 1);
  localparam int DW   = $clog2(MAX_PATTERN_LEN + 1);
  localparam int KW   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int JW   = $clog2(MAX_PATTERN_LEN + 3);
  localparam int ROWW = ALPHABET * NW;

  state_t state, state_next;
  job_t   cur;

  // node store: one row of child pointers per node, plus end tags
  logic [ROWW-1:0]  row_mem [NODES];
  logic [TAG_W-1:0] tag_mem [NODES];
  logic [ROWW-1:0]  rd_row;
  logic [TAG_W-1:0] rd_tag;
  logic [NW-1:0]    ra, wa, ta, twa;
  logic             row_we, tag_we;
  logic [ROWW-1:0]  wd;
  logic [TAG_W-1:0] twd;

  logic [NW-1:0] sweep_addr;
  logic [NW-1:0] load_node;
  logic [DW-1:0] load_depth;
  logic          load_failed;
  logic [UW-1:0] nodes_used;

  logic          w_valid [MAX_PATTERN_LEN];
  logic [NW-1:0] w_node  [MAX_PATTERN_LEN];
  logic [15:0]   w_start [MAX_PATTERN_LEN];
  logic [15:0]   text_pos;

  logic [JW-1:0] step;
  logic          s1_v, s1_root;
  logic [KW-1:0] s1_k;
  logic          s2_v;
  logic [15:0]   s2_start;
  logic [NW-1:0] root_nxt;

  logic             pend_v;
  res_t             pend;
  logic [CNT_W-1:0] res_cnt;

  logic            sym_ok;
  logic [4:0]      sym_i;
  logic [NW-1:0]   child;
  logic            load_ok, err_long, err_full, load_new;
  logic [NW-1:0]   load_nxt;
  logic [ROWW-1:0] row_set;
  logic [KW-1:0]   k_issue;
  logic            issue_v;
  logic            push_v;
  res_t            push_res;
  logic            clear_now;

  assign sym_ok  = int'(cur.symbol) < ALPHABET;
  assign sym_i   = sym_ok ? cur.symbol : 5'd0;
  assign child   = sym_ok ? rd_row[int'(sym_i)*NW +: NW] : '0;
  assign k_issue = KW'(MAX_PATTERN_LEN - 1 - int'(step));

  always_comb begin
    load_new = (child == '0);
    load_nxt = load_new ? nodes_used[NW-1:0] : child;
    err_long = !load_failed && sym_ok && (load_depth >= DW'(MAX_PATTERN_LEN));
    err_full = !load_failed && sym_ok && !err_long && load_new
               && (nodes_used >= UW'(NODES));
    load_ok  = !load_failed && sym_ok && !err_long && !err_full;
    row_set  = rd_row;
    row_set[int'(sym_i)*NW +: NW] = load_nxt;
  end

  assign clear_now = (state == S_IDLE) && q_valid && (q_job.op == OP_CLEAR);
  assign stat      = '{sweeping: (state == S_SWEEP), take: (state == S_IDLE) && q_valid};

  // state and memory port control
  always_comb begin
    state_next = state;
    ra      = load_node;
    row_we  = 1'b0;
    wa      = sweep_addr;
    wd      = '0;
    ta      = child;
    tag_we  = 1'b0;
    twa     = sweep_addr;
    twd     = '0;
    issue_v = 1'b0;
    unique case (state)
      S_SWEEP: begin
        row_we = 1'b1;
        tag_we = 1'b1;
        if (sweep_addr == NW'(NODES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_job.op)
            OP_LOAD:  state_next = S_LOAD;
            OP_TEXT:  state_next = S_TEXT;
            OP_CLEAR: state_next = S_SWEEP;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        if (load_ok && load_new) begin
          row_we = 1'b1;
          wa     = load_node;
          wd     = row_set;
        end
        if (load_ok && cur.last) begin
          tag_we = 1'b1;
          twa    = load_nxt;
          twd    = TAG_W'(cur.pattern_id) + TAG_W'(1);
        end
        state_next = S_DONE;
      end
      S_TEXT: begin
        if (int'(step) < MAX_PATTERN_LEN) begin
          ra      = w_node[k_issue];
          issue_v = w_valid[k_issue];
        end else begin
          ra      = '0;
          issue_v = (int'(step) == MAX_PATTERN_LEN);
        end
        if (int'(step) == MAX_PATTERN_LEN + 2) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    push_res.run_end = 1'b0;
    push_v = 1'b0;
    push_res.match_id = '0;
    push_res.position = '0;
    push_res.status   = ST_MATCH;
    if (state == S_LOAD && (err_long || err_full)) begin
      push_v = 1'b1;
      push_res.status = err_long ? ST_LONG : ST_FULL;
    end else if (state == S_TEXT && s2_v && rd_tag != '0) begin
      push_v = 1'b1;
      push_res.match_id = 6'(rd_tag - TAG_W'(1));
      push_res.position = s2_start;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[wa] <= wd;
    rd_row <= row_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[twa] <= twd;
    rd_tag <= tag_mem[ta];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_SWEEP;
    else     state <= state_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst || clear_now) begin
      sweep_addr  <= '0;
      load_node   <= '0;
      load_depth  <= '0;
      load_failed <= 1'b0;
      nodes_used  <= UW'(1);
      text_pos    <= '0;
      step        <= '0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      pend_v      <= 1'b0;
      res_cnt     <= '0;
      strobe      <= 1'b0;
      for (int i = 0; i < MAX_PATTERN_LEN; i++) w_valid[i] <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (state == S_SWEEP) sweep_addr <= sweep_addr + NW'(1);
      if (stat.take) begin
        step <= '0;
        s1_v <= 1'b0;
        s2_v <= 1'b0;
      end
      if (state == S_LOAD) begin
        if (!load_ok && !load_failed) load_failed <= 1'b1;
        if (load_ok) begin
          if (load_new) nodes_used <= nodes_used + UW'(1);
          load_node  <= load_nxt;
          load_depth <= load_depth + DW'(1);
        end
        if (cur.last) begin
          load_node   <= '0;
          load_depth  <= '0;
          load_failed <= 1'b0;
        end
      end
      if (state == S_TEXT) begin
        step    <= step + JW'(1);
        s1_v    <= issue_v;
        s1_root <= (int'(step) == MAX_PATTERN_LEN);
        s1_k    <= k_issue;
        s2_v    <= s1_v && (child != '0);
        if (s1_v) begin
          s2_start <= s1_root ? text_pos : w_start[s1_k];
          if (s1_root)              root_nxt        <= child;
          else if (child == '0)     w_valid[s1_k]   <= 1'b0;
        end
      end
      if (state == S_DONE && cur.op == OP_TEXT) begin
        for (int i = MAX_PATTERN_LEN - 1; i >= 1; i--) w_valid[i] <= w_valid[i-1];
        w_valid[0] <= (root_nxt != '0);
        if (cur.last) begin
          for (int i = 0; i < MAX_PATTERN_LEN; i++) w_valid[i] <= 1'b0;
          text_pos <= '0;
        end else if (text_pos < 16'(POS_LIMIT)) begin
          text_pos <= text_pos + 16'd1;
        end
      end
      // result stage: hold one back so the final one can carry run_end
      if (push_v && res_cnt < CNT_W'(MAX_RESULTS)) begin
        if (pend_v) begin
          strobe <= 1'b1;
          result <= pend;
        end
        pend    <= push_res;
        pend_v  <= 1'b1;
        res_cnt <= res_cnt + CNT_W'(1);
      end
      if (state == S_DONE) begin
        if (pend_v) begin
          strobe         <= 1'b1;
          result         <= pend;
          result.run_end <= 1'b1;
        end
        pend_v  <= 1'b0;
        res_cnt <= '0;
      end
    end
  end

  // walker payload
  always_ff @(posedge clk) begin
    if (stat.take) cur <= q_job;
    if (state == S_TEXT && s1_v && !s1_root) w_node[s1_k] <= child;
    if (state == S_DONE && cur.op == OP_TEXT) begin
      for (int i = MAX_PATTERN_LEN - 1; i >= 1; i--) begin
        w_node[i]  <= w_node[i-1];
        w_start[i] <= w_start[i-1];
      end
      w_node[0]  <= root_nxt;
      w_start[0] <= text_pos;
    end
  end

endmodule

// File: hdl/trie_multi_pattern_search_core.sv
// Top level of the trie multi-pattern search core.
//
// Usage: drive req and raise start; a request is taken on a clock edge
// where start is high and busy is low. cmd selects pattern load, text
// scan or store clear. Results appear on result with strobe high for one
// cycle each; the last result of a request carries run_end.
// In the back end a pattern symbol passes the load and done states; a text
// symbol is walked with one node-row read per walker slot plus the root,
// pipelined with the end-tag read.
// A two-entry queue sits between intake and execution, so up to two
// requests are taken while the back end works.
// Reset and clear run a sweep over every node address that zeroes
// the node store; busy is high throughout.
// Results cannot be stalled: strobe is a one-cycle pulse.
`include "assert_macros.svh"
module trie_multi_pattern_search_core import tmps_pkg::*; #(
  parameter int NODES           = NODES_DEF,
  parameter int MAX_PATTERN_LEN = MAXLEN_DEF,
  parameter int ALPHABET        = ALPHABET_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic strobe,
  output res_t result
);

  back_stat_t stat;
  logic       q_valid;
  job_t       q_job;

  // intake and decode
  tmps_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .stat    (stat),
    .busy    (busy),
    .q_valid (q_valid),
    .q_job   (q_job)
  );

  // trie store and walkers
  tmps_back #(
    .NODES           (NODES),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .ALPHABET        (ALPHABET)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .stat    (stat),
    .strobe  (strobe),
    .result  (result)
  );

  `ASSERT_IMP(a_sweep_busy, stat.sweeping, busy)
  `ASSERT_IMP(a_sweep_quiet, stat.sweeping, !strobe)
  `ASSERT_IMP(a_err_alone, strobe && result.status != ST_MATCH,
              result.run_end && result.match_id == '0 && result.position == '0)
  `ASSERT_NXT(a_clear_sweeps, stat.take && q_job.op == OP_CLEAR, stat.sweeping)

endmodule

// File: dv/tb_trie_multi_pattern_search_core.sv
// Testbench for the trie multi-pattern search core: directed and random requests, scoreboard.
`timescale 1ns / 100ps
module tb_trie_multi_pattern_search_core;
  import tmps_pkg::*;

  localparam int NODES    = NODES_DEF;
  localparam int MAXLEN   = MAXLEN_DEF;
  localparam int ALPHA    = ALPHABET_DEF;
  localparam int LIMIT    = 2000000;
  localparam int SETTLE   = 2 * NODES + 64;  // clear sweep plus text latency

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic strobe;
  res_t result;

  trie_multi_pattern_search_core uut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .strobe(strobe), .result(result)
  );

  always #5 clk = ~clk;

  // ---- predictor state: our own copy of the trie and the walker window ----
  int unsigned kids [NODES*ALPHA];
  int unsigned tags [NODES];        // 0 untagged, else id + 1
  int unsigned used_nodes;
  int unsigned cur_node, cur_depth;
  bit          cur_dead;
  bit          w_live [MAXLEN];
  int unsigned w_at   [MAXLEN];
  int unsigned w_from [MAXLEN];
  int unsigned text_pos;

  res_t expected_hits[$];           // results still owed by the block
  int   errors = 0;
  int   idle_pct = 0;               // sender gap probability, percent
  int   n_req = 0, n_hits = 0, n_full = 0, n_long = 0;
  int   cycles = 0;

  function automatic void trie_clear();
    foreach (kids[i]) kids[i] = 0;
    foreach (tags[i]) tags[i] = 0;
    used_nodes = 1;
    cur_node = 0; cur_depth = 0; cur_dead = 0;
    foreach (w_live[i]) begin
      w_live[i] = 0; w_at[i] = 0; w_from[i] = 0;
    end
    text_pos = 0;
  endfunction

  function automatic int unsigned kid_of(int unsigned nd, int unsigned s);
    if (nd >= NODES || s >= ALPHA) return 0;
    return kids[nd*ALPHA + s];
  endfunction

  function automatic void owe(ref res_t q[$], input int unsigned id,
                              input int unsigned pos, input logic [1:0] st);
    res_t r;
    if (q.size() >= MAX_RESULTS) return;
    r.match_id = id[5:0];
    r.position = pos[15:0];
    r.status   = st;
    r.run_end  = 1'b0;
    q = {q, r};
  endfunction

  // Work out the results one request causes and advance the model state.
  function automatic void predict_search(req_t rq);
    res_t q[$];
    int unsigned s, nx;
    s = rq.symbol;
    if (rq.cmd == CMD_PATTERN) begin
      if (!cur_dead) begin
        if (s >= ALPHA) cur_dead = 1;
        else if (cur_depth >= MAXLEN) begin
          cur_dead = 1; owe(q, 0, 0, ST_LONG);
        end else begin
          nx = kid_of(cur_node, s);
          if (nx == 0) begin
            if (used_nodes >= NODES) begin
              cur_dead = 1; owe(q, 0, 0, ST_FULL);
            end else begin
              nx = used_nodes; used_nodes++;
              kids[cur_node*ALPHA + s] = nx;
            end
          end
          if (!cur_dead) begin
            cur_node = nx; cur_depth++;
            if (rq.last) tags[nx] = rq.pattern_id + 1;
          end
        end
      end
      if (rq.last) begin
        cur_node = 0; cur_depth = 0; cur_dead = 0;
      end
    end else if (rq.cmd == CMD_TEXT) begin
      // oldest walker first, so start positions come out ascending
      for (int k = MAXLEN-1; k >= 0; k--) begin
        if (!w_live[k]) continue;
        nx = kid_of(w_at[k], s);
        if (nx == 0) w_live[k] = 0;
        else begin
          w_at[k] = nx;
          if (tags[nx] != 0) owe(q, tags[nx]-1, w_from[k], ST_MATCH);
        end
      end
      for (int k = MAXLEN-1; k >= 1; k--) begin
        w_live[k] = w_live[k-1]; w_at[k] = w_at[k-1]; w_from[k] = w_from[k-1];
      end
      nx = kid_of(0, s);
      w_live[0] = (nx != 0); w_at[0] = nx; w_from[0] = text_pos;
      if (nx != 0 && tags[nx] != 0) owe(q, tags[nx]-1, text_pos, ST_MATCH);
      if (text_pos < POS_LIMIT) text_pos++;
      if (rq.last) begin
        foreach (w_live[i]) w_live[i] = 0;
        text_pos = 0;
      end
    end else if (rq.cmd == CMD_CLEAR) begin
      trie_clear();
    end
    if (q.size() > 0) q[$].run_end = 1'b1;
    foreach (q[i]) expected_hits = {expected_hits, q[i]};
  endfunction

  // ---- result checker: every strobe pulse is compared to the oldest entry ----
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_hits.size() == 0) begin
        $error("unexpected result id=%0d pos=%0d status=%0d",
               result.match_id, result.position, result.status);
        errors++;
      end else begin
        res_t e;
        e = expected_hits.pop_front();
        if (result.match_id !== e.match_id) begin
          $error("match_id exp %0d got %0d", e.match_id, result.match_id); errors++;
        end
        if (result.position !== e.position) begin
          $error("position exp %0d got %0d", e.position, result.position); errors++;
        end
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status); errors++;
        end
        if (result.run_end !== e.run_end) begin
          $error("run_end exp %0d got %0d", e.run_end, result.run_end); errors++;
        end
        if (e.status == ST_MATCH) n_hits++;
        else if (e.status == ST_FULL) n_full++;
        else n_long++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---- request driver ----
  // start stays high after an accepted request; drain() or a random gap in the next call lowers it
  task automatic send_request(logic [1:0] c, int unsigned s, bit l, int unsigned pid);
    req_t rq;
    rq = '{cmd: c, symbol: s[4:0], last: l, pattern_id: pid[5:0]};
    // random gap before the request, start held low
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    req <= rq;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_search(rq);
    n_req++;
  endtask

  task automatic send_word(string w, int unsigned pid);
    for (int i = 0; i < w.len(); i++)
      send_request(CMD_PATTERN, w[i] - "a", i == w.len()-1, pid);
  endtask

  task automatic send_text(string w);
    for (int i = 0; i < w.len(); i++)
      send_request(CMD_TEXT, w[i] - "a", i == w.len()-1, 0);
  endtask

  // pause the sender until every owed result has come
  task automatic drain();
    start <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---- tests ----
  task automatic test_basic_match();
    send_word("he", 0);
    send_word("she", 63);
    send_word("his", 5);
    send_word("he", 7);                       // duplicate overwrites the tag
    send_text("ushers");
    send_request(CMD_TEXT, 25, 1'b1, 0);      // z, end of text
  endtask

  task automatic test_odd_symbols();
    send_request(CMD_PATTERN, 31, 1'b0, 0);   // out of alphabet drops pattern
    send_request(CMD_PATTERN, 0, 1'b1, 9);
    send_request(CMD_PATTERN, 0, 1'b1, 10);   // single "a"
    send_text("aa");
    send_request(CMD_TEXT, 26, 1'b0, 0);      // walkers die
    send_request(CMD_TEXT, 0, 1'b1, 0);
    send_request(2'd3, 31, 1'b1, 63);         // unused command
  endtask

  task automatic test_too_long();
    for (int i = 0; i <= MAXLEN + 1; i++)
      send_request(CMD_PATTERN, 1, i == MAXLEN + 1, 3);
    for (int i = 0; i < 4; i++)
      send_request(CMD_TEXT, 1, i == 3, 0);
  endtask

  task automatic test_random(int count, bit reload);
    string w;
    int pid;
    if (reload) begin
      send_request(CMD_CLEAR, 0, 1'b0, 0);
      for (int i = 0; i < 8; i++) begin
        w = "";
        for (int j = $urandom_range(1, 4); j > 0; j--)
          w = {w, string'(byte'("a" + $urandom_range(0, 3)))};
        pid = $urandom_range(0, 63);
        send_word(w, pid);
      end
    end
    for (int i = 0; i < count; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) send_request(CMD_TEXT, $urandom_range(0, 3), $urandom_range(0, 30) == 0, 0);
      else if (r < 93) send_request(CMD_PATTERN, $urandom_range(0, 4),
                                    $urandom_range(0, 2) == 0, $urandom_range(0, 63));
      else send_request(CMD_TEXT, $urandom_range(0, 31), $urandom_range(0, 1), 0);
    end
    send_request(CMD_PATTERN, 0, 1'b1, 0);    // close any open pattern
    send_request(CMD_TEXT, 0, 1'b1, 0);
  endtask

  initial begin
    trie_clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 0;
    test_basic_match();
    test_odd_symbols();
    test_too_long();
    drain();
    idle_pct = 0;  test_random(12, 1'b1);
    idle_pct = 53; test_random(12, 1'b0);
    drain();
    idle_pct = 38; test_random(12, 1'b0);
    idle_pct = 0;  test_random(12, 1'b0);

    drain();
    $display("Sent %0d requests; checked %0d matches, %0d store-full, %0d too-long.",
             n_req, n_hits, n_full, n_long);
    if (errors == 0 && expected_hits.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
